FILE: design/pgm_pkg.sv
// Shared types and constants for the Prewitt gradient magnitude block.
// No dependencies; imported by pgm_ctrl, pgm_isqrt, pgm_datapath and the top level.
`default_nettype none

package pgm_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W    = 8;
    localparam int FW_W     = 12;
    localparam int FH_W     = 16;
    localparam int GRAD_W   = 11;
    localparam int SUM_W    = 10;
    localparam int ROOT_W   = 11;
    localparam int SQ_W     = 21;
    localparam int ITER_W   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    typedef struct packed {
        logic accept;
        logic window_step;
        logic grad_load;
        logic root_start;
        logic out_load;
    } pgm_cmd_t;

    typedef struct packed {
        logic produce;
        logic root_busy;
        logic out_free;
    } pgm_status_t;

endpackage

`default_nettype wire

FILE: design/pgm_ctrl.sv
// Sequencer for the Prewitt block: accepts one pixel, steps the datapath through
// window update, gradients, square root and output load. Depends on pgm_pkg.
`default_nettype none

module pgm_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire pgm_pkg::pgm_status_t status,
    output pgm_pkg::pgm_cmd_t   cmd
);
    import pgm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WIN  = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_WIN;
                end
            end
            S_WIN: begin
                cmd.window_step = 1'b1;
                state_next = status.produce ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
                cmd.grad_load = 1'b1;
                state_next = S_SQR;
            end
            S_SQR: begin
                cmd.root_start = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT: begin
                if (!status.root_busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output word loaded while still occupied");

    a_accept_then_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> cmd.window_step)
        else $error("window step did not follow accepted pixel");

    a_wait_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROOT && status.root_busy) |=> (state_reg == S_ROOT))
        else $error("left root wait while unit busy");

endmodule

`default_nettype wire

FILE: design/pgm_isqrt.sv
// Bit-serial floor square root, one result bit per cycle (restoring method).
// Depends on pgm_pkg for operand and root widths.
`default_nettype none

module pgm_isqrt (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        start,
    input  wire  [pgm_pkg::SQ_W-1:0]   value,
    output logic [pgm_pkg::ROOT_W-1:0] root,
    output logic                       busy
);
    import pgm_pkg::*;

    localparam int VAL_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic [VAL_W-1:0]  val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;

    logic [REM_W+1:0]  rem_shift;
    logic [REM_W:0]    trial;
    logic              take;

    assign rem_shift = {rem_reg, val_reg[VAL_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = rem_shift >= {1'b0, trial};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= ITER_W'(ROOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= VAL_W'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= {val_reg[VAL_W-3:0], 2'b00};
            if (take) begin
                rem_reg  <= REM_W'(rem_shift - (REM_W+2)'(trial));
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= REM_W'(rem_shift);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: design/pgm_datapath.sv
// Datapath: config registers, raster counters, two line memories, 3x3 window,
// Prewitt sums, squaring, root unit and output register. Uses pgm_pkg, pgm_isqrt.
`default_nettype none

module pgm_datapath #(
    parameter int MAX_WIDTH = pgm_pkg::MAX_WIDTH_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire pgm_pkg::pgm_cmd_t          cmd,
    output pgm_pkg::pgm_status_t            status,
    input  wire  [pgm_pkg::PIX_W-1:0]       pixel,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [pgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [pgm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [pgm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic [0:0]                      m_tuser
);
    import pgm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [COL_W-1:0] col_reg;
    logic [FH_W-1:0]  row_reg;
    logic             cfg_hit;

    logic [EW_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;
    logic             row_last_now;
    logic             row_end_now;

    logic [PIX_W-1:0] mem_upper [MAX_WIDTH];
    logic [PIX_W-1:0] mem_lower [MAX_WIDTH];
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] upper_rd_reg;
    logic [PIX_W-1:0] lower_rd_reg;
    logic [PIX_W-1:0] win_reg [9];
    logic             rl_reg;
    logic             fl_reg;

    logic [SUM_W-1:0]         sum_left, sum_right, sum_top, sum_bottom;
    logic signed [GRAD_W-1:0] gh_reg, gv_reg;
    logic signed [2*GRAD_W-1:0] gh_ext, gv_ext, ph, pv;
    logic [SQ_W-1:0]          sq;
    logic [ROOT_W-1:0]        root;
    logic                     root_busy;

    logic                     out_valid_reg;
    logic signed [GRAD_W-1:0] out_gh_reg, out_gv_reg;
    logic [ROOT_W-1:0]        out_mag_reg;
    logic                     out_rl_reg, out_fl_reg;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < FW_W'(3)) begin
            eff_w = EW_W'(3);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(width_reg);
        end
        eff_h = (height_reg < FH_W'(3)) ? FH_W'(3) : height_reg;
    end

    // raster position
    assign row_last_now   = (EW_W'(col_reg) + EW_W'(1)) >= eff_w;
    assign row_end_now    = ((FH_W+1)'(row_reg) + (FH_W+1)'(1)) >= (FH_W+1)'(eff_h);
    assign status.produce = (col_reg >= COL_W'(2)) && (row_reg >= FH_W'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_hit) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.window_step) begin
            if (row_last_now) begin
                col_reg <= '0;
                row_reg <= row_end_now ? '0 : row_reg + FH_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // line memories: read on accept, write back during the window step
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            upper_rd_reg <= mem_upper[col_reg];
        end
        if (cmd.window_step) begin
            mem_upper[col_reg] <= lower_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lower_rd_reg <= mem_lower[col_reg];
            pix_reg      <= pixel;
        end
        if (cmd.window_step) begin
            mem_lower[col_reg] <= pix_reg;
        end
    end

    // 3x3 window, row 0 on top, new column enters on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.window_step) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= upper_rd_reg;
            win_reg[5] <= lower_rd_reg;
            win_reg[8] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.window_step) begin
            rl_reg <= row_last_now;
            fl_reg <= row_last_now && row_end_now;
        end
    end

    // Prewitt sums
    assign sum_left   = SUM_W'(win_reg[0]) + SUM_W'(win_reg[3]) + SUM_W'(win_reg[6]);
    assign sum_right  = SUM_W'(win_reg[2]) + SUM_W'(win_reg[5]) + SUM_W'(win_reg[8]);
    assign sum_top    = SUM_W'(win_reg[0]) + SUM_W'(win_reg[1]) + SUM_W'(win_reg[2]);
    assign sum_bottom = SUM_W'(win_reg[6]) + SUM_W'(win_reg[7]) + SUM_W'(win_reg[8]);

    always_ff @(posedge aclk) begin
        if (cmd.grad_load) begin
            gh_reg <= $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
            gv_reg <= $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});
        end
    end

    // squares feed the root unit directly
    assign gh_ext = (2*GRAD_W)'(gh_reg);
    assign gv_ext = (2*GRAD_W)'(gv_reg);
    assign ph     = gh_ext * gh_ext;
    assign pv     = gv_ext * gv_ext;
    assign sq     = SQ_W'(ph) + SQ_W'(pv);

    pgm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.root_start),
        .value   (sq),
        .root    (root),
        .busy    (root_busy)
    );

    assign status.root_busy = root_busy;

    // output register
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_gh_reg  <= gh_reg;
            out_gv_reg  <= gv_reg;
            out_mag_reg <= root;
            out_rl_reg  <= rl_reg;
            out_fl_reg  <= fl_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - GRAD_W - GRAD_W - ROOT_W)'(0),
                       out_mag_reg, out_gv_reg, out_gh_reg};
    assign m_tlast  = out_rl_reg;
    assign m_tuser  = out_fl_reg;

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        EW_W'(col_reg) < eff_w)
        else $error("column counter beyond row width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg < eff_h)
        else $error("row counter beyond frame height");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded word not presented");

endmodule

`default_nettype wire

FILE: design/prewitt_gradient_magnitude.sv
// Top level of the 3x3 Prewitt gradient magnitude block: controller plus datapath.
// Depends on pgm_pkg, pgm_ctrl, pgm_datapath (and pgm_isqrt below it).
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid/s_tready    s_tdata[7:0] gray_pixel
//   m_        out   m_tvalid/m_tready    m_tdata, m_tlast row_last, m_tuser frame_last
//   cfg_      in    cfg_valid/cfg_ready  cfg_index (0 width, 1 height), cfg_data
//
// A pixel with no result passes through accept and window; one with a result passes through
// accept, window, sums, square, the bit-serial square root (11 root bits, one per cycle, then
// done seen) and the output load. Reset is synchronous, active low, and needs no clearing pass.
// A stalled result waits in the output register; the next pixel is accepted meanwhile and
// its result waits in the datapath until the output register frees.
`default_nettype none

module prewitt_gradient_magnitude #(
    parameter int MAX_WIDTH = pgm_pkg::MAX_WIDTH_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [pgm_pkg::PIX_W-1:0]       s_tdata,   // [7:0] gray_pixel
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [pgm_pkg::OUT_DATA_W-1:0]  m_tdata,   // [10:0] grad_horizontal,
                                                       // [21:11] grad_vertical,
                                                       // [32:22] magnitude, rest zero
    output logic                            m_tlast,   // row_last
    output logic [0:0]                      m_tuser,   // [0] frame_last
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [pgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [pgm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pgm_pkg::*;

    pgm_cmd_t    cmd;
    pgm_status_t status;

    pgm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pgm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .pixel     (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/pgm_scoreboard.sv
// Scoreboard for the Prewitt gradient magnitude testbench: a pixel-level predictor
// of the 3x3 window and line stores, plus the queue of gradient words still due.
// Depends on pgm_pkg for register indexes, reset values and the line depth.
`timescale 1ns / 1ps

package pgm_tb_pkg;

    import pgm_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH_DEF;

    typedef struct {
        logic signed [GRAD_W-1:0] grad_h;
        logic signed [GRAD_W-1:0] grad_v;
        logic        [ROOT_W-1:0] magnitude;
        logic        [6:0]        padding;
        logic                     row_last;
        logic                     frame_last;
    } grad_word_t;

    class prewitt_scoreboard;

        bit [PIX_W-1:0] upper_line [LINE_DEPTH];
        bit [PIX_W-1:0] lower_line [LINE_DEPTH];
        bit [PIX_W-1:0] win [9];
        int unsigned    width_cfg;
        int unsigned    height_cfg;
        int unsigned    col;
        int unsigned    row;
        grad_word_t     due_words [$];
        int             errors;

        function new();
            width_cfg  = 32'(FRAME_WIDTH_RST);
            height_cfg = 32'(FRAME_HEIGHT_RST);
            col        = 0;
            row        = 0;
            errors     = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function int unsigned floor_root(int unsigned v);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int b = 10; b >= 0; b--) begin
                trial = root | (32'd1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        // a write to either register restarts the frame; other indexes are dropped
        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FRAME_WIDTH) begin
                width_cfg = 32'(data[FW_W-1:0]);
            end else if (idx == REG_FRAME_HEIGHT) begin
                height_cfg = 32'(data);
            end else begin
                return;
            end
            col = 0;
            row = 0;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int unsigned    w;
            int unsigned    h;
            bit [PIX_W-1:0] top;
            bit [PIX_W-1:0] mid;
            int             left;
            int             right;
            int             upper;
            int             lower;
            int             gh;
            int             gv;
            grad_word_t     word;
            w = (width_cfg < 3) ? 3 : ((width_cfg > LINE_DEPTH) ? LINE_DEPTH : width_cfg);
            h = (height_cfg < 3) ? 3 : height_cfg;
            top = upper_line[col];
            mid = lower_line[col];
            upper_line[col] = mid;
            lower_line[col] = pix;
            for (int k = 0; k < 3; k++) begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = pix;
            if (col >= 2 && row >= 2) begin
                left  = int'(win[0]) + int'(win[3]) + int'(win[6]);
                right = int'(win[2]) + int'(win[5]) + int'(win[8]);
                upper = int'(win[0]) + int'(win[1]) + int'(win[2]);
                lower = int'(win[6]) + int'(win[7]) + int'(win[8]);
                gh = left - right;
                gv = upper - lower;
                word.grad_h     = gh[GRAD_W-1:0];
                word.grad_v     = gv[GRAD_W-1:0];
                word.magnitude  = ROOT_W'(floor_root(gh * gh + gv * gv));
                word.padding    = '0;
                word.row_last   = (col + 1 >= w);
                word.frame_last = word.row_last && (row + 1 >= h);
                due_words = {due_words, word};
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void report(string field, int want, int got);
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        endfunction

        function void check_result(grad_word_t got);
            grad_word_t want;
            if (due_words.size() == 0) begin
                $error("unexpected word: gh %0d gv %0d mag %0d",
                       got.grad_h, got.grad_v, got.magnitude);
                errors++;
                return;
            end
            want = due_words.pop_front();
            if (got.grad_h !== want.grad_h)
                report("grad_horizontal", want.grad_h, got.grad_h);
            if (got.grad_v !== want.grad_v)
                report("grad_vertical", want.grad_v, got.grad_v);
            if (got.magnitude !== want.magnitude)
                report("magnitude", want.magnitude, got.magnitude);
            if (got.padding !== want.padding)
                report("tdata_padding", want.padding, got.padding);
            if (got.row_last !== want.row_last)
                report("row_last", want.row_last, got.row_last);
            if (got.frame_last !== want.frame_last)
                report("frame_last", want.frame_last, got.frame_last);
        endfunction

    endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for prewitt_gradient_magnitude: drives pixel frames and register
// writes, stalls the result side, and checks each gradient word against the scoreboard.
// Depends on pgm_pkg, pgm_tb_pkg and the block under test.
`timescale 1ns / 1ps

module tb;

    import pgm_pkg::*;
    import pgm_tb_pkg::*;

    typedef enum int { RX_OPEN, RX_COIN, RX_STALLS } rx_mode_t;
    typedef enum int { PIX_RANDOM, PIX_EXTREME, PIX_MIXED } pix_style_t;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_FRAME_HEIGHT + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;
    localparam int                   RANDOM_PIXELS    = 720;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tlast;
    wire [0:0]             m_tuser;
    wire                   cfg_ready;

    prewitt_gradient_magnitude dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    prewitt_scoreboard     sb;
    logic [PIX_W-1:0]      pix_q [$];
    logic [CFG_DATA_W-1:0] cur_w = CFG_DATA_W'(FRAME_WIDTH_RST);
    logic [CFG_DATA_W-1:0] cur_h = CFG_DATA_W'(FRAME_HEIGHT_RST);

    rx_mode_t rx_mode       = RX_OPEN;
    int       rx_mode_left  = 0;
    int       rx_stall_left = 0;
    logic     rx_ready;

    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN: begin
                rx_ready = 1'b1;
            end
            RX_COIN: begin
                rx_ready = 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    rx_ready = 1'b0;
                end else begin
                    rx_ready = 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 30);
                end
            end
        endcase
        m_tready <= rx_ready;
    end

    always @(posedge aclk) begin
        grad_word_t word;
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
            if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
            if (m_tvalid && m_tready) begin
                word.grad_h     = m_tdata[10:0];
                word.grad_v     = m_tdata[21:11];
                word.magnitude  = m_tdata[32:22];
                word.padding    = m_tdata[39:33];
                word.row_last   = m_tlast;
                word.frame_last = m_tuser[0];
                sb.check_result(word);
            end
        end
    end

    function int eff_width(logic [CFG_DATA_W-1:0] d);
        int w;
        w = d[FW_W-1:0];
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function int eff_height(logic [CFG_DATA_W-1:0] d);
        return (d < 3) ? 3 : int'(d);
    endfunction

    function logic [PIX_W-1:0] pick_pixel(pix_style_t style);
        case (style)
            PIX_RANDOM:  return PIX_W'($urandom_range(0, 255));
            PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default:     return ($urandom_range(0, 1) != 0) ? PIX_W'($urandom_range(0, 255))
                                 : (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
        endcase
    endfunction

    task automatic fill_pixels(int n, pix_style_t style);
        repeat (n) pix_q = {pix_q, pick_pixel(style)};
    endtask

    // entered and left at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cur_w = data;
        if (idx == REG_FRAME_HEIGHT) cur_h = data;
        @(negedge aclk);
    endtask

    task automatic send_pixels();
        int burst_left;
        int gap;
        burst_left = 0;
        while (pix_q.size() != 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 40);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= pix_q.pop_front();
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            @(negedge aclk);
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    // pixels without a word may still be in flight once the queue is empty
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        #25_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int random_pixels;
        int n;
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 3x3 frames: strong left edge, then bottom-right corner
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        pix_q = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
                  8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
        send_pixels();
        wait_idle();

        // sizes below the minimum clamp to 3
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        fill_pixels(18, PIX_EXTREME);
        send_pixels();
        wait_idle();

        // width above the line depth; high data bits ignored, no word in the first row
        write_reg(REG_FRAME_WIDTH, 16'hFFFF);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        fill_pixels(40, PIX_MIXED);
        send_pixels();
        wait_idle();

        write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(LINE_DEPTH));
        fill_pixels(50, PIX_RANDOM);
        send_pixels();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 16'd6);
        fill_pixels(60, PIX_MIXED);
        send_pixels();
        wait_idle();

        // unused indexes mid-frame must not restart the frame
        write_reg(REG_FRAME_WIDTH, 16'd5);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        fill_pixels(13, PIX_RANDOM);
        send_pixels();
        wait_idle();
        write_reg(REG_UNUSED_FIRST, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        fill_pixels(20, PIX_RANDOM);
        send_pixels();
        wait_idle();
        write_reg(REG_UNUSED_LAST, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
        fill_pixels(7, PIX_MIXED);
        send_pixels();
        wait_idle();

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            if ($urandom_range(0, 9) == 0) w_data = CFG_DATA_W'($urandom_range(0, 2));
            else if ($urandom_range(0, 9) == 0) w_data = CFG_DATA_W'($urandom_range(13, 64));
            else w_data = CFG_DATA_W'($urandom_range(3, 12));
            if ($urandom_range(0, 7) == 0) w_data[15:12] = 4'($urandom_range(1, 15));
            h_data = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                                 : CFG_DATA_W'($urandom_range(3, 6));
            case ($urandom_range(0, 3))
                0: begin
                    write_reg(REG_FRAME_WIDTH, w_data);
                end
                1: begin
                    write_reg(REG_FRAME_HEIGHT, h_data);
                end
                2: begin
                    write_reg(REG_FRAME_HEIGHT, h_data);
                    write_reg(REG_FRAME_WIDTH, w_data);
                end
                default: begin
                    write_reg(REG_FRAME_WIDTH, w_data);
                    write_reg(REG_FRAME_HEIGHT, h_data);
                end
            endcase
            n = eff_width(cur_w) * eff_height(cur_h) * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
            fill_pixels(n, pix_style_t'($urandom_range(0, 2)));
            send_pixels();
            random_pixels += n;
            wait_idle();
            if ($urandom_range(0, 4) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                          CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
                n = $urandom_range(1, 30);
                fill_pixels(n, PIX_RANDOM);
                send_pixels();
                random_pixels += n;
                wait_idle();
            end
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
